// File: design/dtsm_pkg.sv
// Shared constants, types, sine table and control structures of the dual-tone sine mixer.
package dtsm_pkg;

	// Field and register widths.
	localparam int PHASE_W  = 16;
	localparam int PERIOD_W = 16;
	localparam int SAMPLE_W = 8;
	localparam int TONE_W   = 9;
	localparam int SUM_W    = 10;
	localparam int DATA_W   = 16;
	localparam int REG_IDX_W = 1;

	// Sine table size and the derived divider geometry.
	localparam int SINE_ENTRIES = 1024;
	localparam int SINE_AW      = $clog2(SINE_ENTRIES);
	localparam int NUM_W        = PHASE_W + SINE_AW;
	localparam int CNT_W        = $clog2(NUM_W);

	// Register indexes on the write port.
	localparam logic [REG_IDX_W-1:0] REG_PERIOD_ONE = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_PERIOD_TWO = 1'b1;

	// Reset values of the period registers.
	localparam logic [PERIOD_W-1:0] PERIOD_ONE_RST = 16'd685;
	localparam logic [PERIOD_W-1:0] PERIOD_TWO_RST = 16'd675;

	// Saturation limits of the output sample.
	localparam logic signed [SUM_W-1:0] SAMPLE_MAX = 10'sd127;
	localparam logic signed [SUM_W-1:0] SAMPLE_MIN = -10'sd128;

	typedef logic signed [TONE_W-1:0] tone_t;
	typedef tone_t sine_table_t [SINE_ENTRIES];

	// One table entry: 150 * sin(2*pi*k/SINE_ENTRIES), truncated toward zero,
	// computed with a Q30 polynomial so that every tool builds the same table.
	function automatic tone_t sine_entry(input longint unsigned k);
		longint unsigned one;
		longint unsigned half_pi;
		longint unsigned q;
		longint unsigned r;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned t;
		longint unsigned s;
		longint unsigned m;
		one     = 64'd1073741824;
		half_pi = 64'd1686629713;
		q = (k * 4) / SINE_ENTRIES;
		r = k * 4 - q * SINE_ENTRIES;
		if (q[0]) begin
			r = SINE_ENTRIES - r;
		end
		x  = (r * half_pi) / SINE_ENTRIES;
		x2 = (x * x) >> 30;
		t  = one;
		t  = one - (((x2 * t) >> 30) / 156);
		t  = one - (((x2 * t) >> 30) / 110);
		t  = one - (((x2 * t) >> 30) / 72);
		t  = one - (((x2 * t) >> 30) / 42);
		t  = one - (((x2 * t) >> 30) / 20);
		t  = one - (((x2 * t) >> 30) / 6);
		s  = (x * t) >> 30;
		m  = (150 * s + 1024) >> 30;
		if (q >= 2) begin
			return -TONE_W'(m);
		end
		return TONE_W'(m);
	endfunction

	// Whole table, built at elaboration.
	function automatic sine_table_t build_sine_table();
		sine_table_t tab;
		for (int k = 0; k < SINE_ENTRIES; k++) begin
			tab[k] = sine_entry(longint'(k));
		end
		return tab;
	endfunction

	localparam sine_table_t SINE_TABLE = build_sine_table();

	// Controller states.
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DIV  = 4'b0010,
		ST_LOOK = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic step;
		logic look;
		logic finish;
	} dtsm_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_busy;
	} dtsm_status_t;

endpackage

// File: design/dtsm_req_if.sv
// Request channel: one request per sample, carrying the end-of-buffer marker.
interface dtsm_req_if import dtsm_pkg::*; ();
	logic valid;
	logic ready;
	logic end_of_buffer;

	modport source (output valid, output end_of_buffer, input ready);
	modport sink (input valid, input end_of_buffer, output ready);
endinterface

// File: design/dtsm_res_if.sv
// Result channel: one signed sample and its last marker per request.
interface dtsm_res_if import dtsm_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       last;

	modport source (output valid, output sample, output last, input ready);
	modport sink (input valid, input sample, input last, output ready);
endinterface

// File: design/dtsm_ctrl.sv
// Controller of the dual-tone sine mixer: sequences division, table read and output.
module dtsm_ctrl import dtsm_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         req_valid,
	output logic         req_ready,
	output dtsm_cmd_t    cmd,
	input  dtsm_status_t status
);

	state_t           state_q;
	state_t           state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             last_step;

	assign last_step = (cnt_q == CNT_W'(NUM_W - 1));
	assign req_ready = (state_q == ST_IDLE);

	// Commands follow the state directly.
	always_comb begin
		cmd.load   = req_valid && req_ready;
		cmd.step   = (state_q == ST_DIV);
		cmd.look   = (state_q == ST_LOOK);
		cmd.finish = (state_q == ST_EMIT) && !status.out_busy;
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (last_step) begin
					state_d = ST_LOOK;
				end
			end
			ST_LOOK: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (!status.out_busy) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register and the division step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				cnt_q <= '0;
			end else if (cmd.step) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// A result is only written into a free output register.
	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !status.out_busy)
		else $error("finish issued while output register is occupied");

	// An accepted request always starts the division.
	a_load_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == ST_DIV) && (cnt_q == '0))
		else $error("accepted request did not start the division");

	// After the result is written the controller is ready again.
	a_finish_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> req_ready)
		else $error("controller not idle after result was written");

endmodule

// File: design/dtsm_datapath.sv
// Datapath of the dual-tone sine mixer: period registers, phases, dividers, table and output.
module dtsm_datapath import dtsm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 write_enable,
	input  logic [REG_IDX_W-1:0] write_index,
	input  logic [DATA_W-1:0]    write_data,
	input  logic                 end_of_buffer,
	input  dtsm_cmd_t            cmd,
	output dtsm_status_t         status,
	dtsm_res_if.source           result
);

	logic [PERIOD_W-1:0]        period_q [2];
	logic [PHASE_W-1:0]         phase_q  [2];
	logic [PERIOD_W-1:0]        div_p    [2];
	logic [NUM_W-1:0]           num_q    [2];
	logic [PERIOD_W-1:0]        rem_q    [2];
	logic [SINE_AW-1:0]         qmod_q   [2];
	tone_t                      tone_q   [2];
	logic [NUM_W-1:0]           num_d    [2];
	logic [PERIOD_W-1:0]        rem_d    [2];
	logic [SINE_AW-1:0]         qmod_d   [2];
	logic [PHASE_W-1:0]         phase_d  [2];
	logic [PERIOD_W:0]          rem_sh   [2];
	logic [SINE_AW:0]           q_sh     [2];
	logic [PHASE_W:0]           phase_inc[2];
	logic                       ge       [2];
	logic                       last_q;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic                       out_last_q;
	logic signed [SUM_W-1:0]    sum;
	logic signed [SAMPLE_W-1:0] sat;

	// Configuration registers; a zero period acts as one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q[0] <= PERIOD_ONE_RST;
			period_q[1] <= PERIOD_TWO_RST;
		end else if (write_enable) begin
			case (write_index)
				REG_PERIOD_ONE: period_q[0] <= write_data;
				REG_PERIOD_TWO: period_q[1] <= write_data;
				default: ;
			endcase
		end
	end

	// One restoring division step per lane. The quotient is kept reduced
	// modulo the table size, so a phase above its period still indexes right.
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			div_p[l]     = (period_q[l] == '0) ? PERIOD_W'(1) : period_q[l];
			rem_sh[l]    = {rem_q[l], num_q[l][NUM_W-1]};
			ge[l]        = (rem_sh[l] >= {1'b0, div_p[l]});
			rem_d[l]     = ge[l] ? PERIOD_W'(rem_sh[l] - {1'b0, div_p[l]})
			                     : rem_sh[l][PERIOD_W-1:0];
			q_sh[l]      = {qmod_q[l], ge[l]};
			qmod_d[l]    = (q_sh[l] >= (SINE_AW + 1)'(SINE_ENTRIES))
			               ? SINE_AW'(q_sh[l] - (SINE_AW + 1)'(SINE_ENTRIES))
			               : q_sh[l][SINE_AW-1:0];
			num_d[l]     = {num_q[l][NUM_W-2:0], 1'b0};
			phase_inc[l] = {1'b0, phase_q[l]} + 1'b1;
			phase_d[l]   = (phase_inc[l] >= {1'b0, div_p[l]}) ? '0
			                                                  : phase_inc[l][PHASE_W-1:0];
		end
	end

	// Divider registers and registered table reads.
	always_ff @(posedge clk) begin
		for (int l = 0; l < 2; l++) begin
			if (cmd.load) begin
				num_q[l]  <= NUM_W'(phase_q[l]) * NUM_W'(SINE_ENTRIES);
				rem_q[l]  <= '0;
				qmod_q[l] <= '0;
			end else if (cmd.step) begin
				num_q[l]  <= num_d[l];
				rem_q[l]  <= rem_d[l];
				qmod_q[l] <= qmod_d[l];
			end
			if (cmd.look) begin
				tone_q[l] <= SINE_TABLE[qmod_q[l]];
			end
		end
		if (cmd.load) begin
			last_q <= end_of_buffer;
		end
	end

	// Phase counters advance when the sample is written into the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q[0] <= '0;
			phase_q[1] <= '0;
		end else if (cmd.finish) begin
			phase_q[0] <= phase_d[0];
			phase_q[1] <= phase_d[1];
		end
	end

	// Mix both tones and saturate to the sample range.
	always_comb begin
		sum = SUM_W'(tone_q[0]) + SUM_W'(tone_q[1]);
		if (sum > SAMPLE_MAX) begin
			sat = SAMPLE_MAX[SAMPLE_W-1:0];
		end else if (sum < SAMPLE_MIN) begin
			sat = SAMPLE_MIN[SAMPLE_W-1:0];
		end else begin
			sat = sum[SAMPLE_W-1:0];
		end
	end

	// Output register: holds the result until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			sample_q   <= sat;
			out_last_q <= last_q;
		end
	end

	assign result.valid    = out_valid_q;
	assign result.sample   = sample_q;
	assign result.last     = out_last_q;
	assign status.out_busy = out_valid_q && !result.ready;

	// The partial remainder of each lane always stays below its divisor.
	a_rem_one: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> rem_q[0] < div_p[0])
		else $error("remainder of tone one out of range");

	a_rem_two: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> rem_q[1] < div_p[1])
		else $error("remainder of tone two out of range");

	// A written result is offered on the next cycle.
	a_finish_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> result.valid)
		else $error("written result not offered");

endmodule

// File: design/dual_tone_sine_mixer_core.sv
// Top level of the dual-tone sine mixer: controller, datapath and ports.
// Each request yields one signed 8-bit sample: the sum of two table sines
// (amplitude 150), one per period register, saturated to -128..127, with the
// request's end-of-buffer marker copied to last. Both phases then advance and
// wrap at their periods; a period of zero behaves as one. The two tone indexes
// floor(phase*SINE_ENTRIES/period) come from two restoring dividers that
// produce one quotient bit per cycle, followed by a registered table read and
// the mixing into the output register, after which the result is offered. The
// next request is accepted as soon as the result is in the output register,
// even while the sink has not yet taken it; only a result still waiting when
// the next one is ready stalls the block. The user must write the period
// registers through the plain write port only while the block is idle; the
// block itself does not enforce this.
module dual_tone_sine_mixer_core import dtsm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 write_enable,
	input  logic [REG_IDX_W-1:0] write_index,
	input  logic [DATA_W-1:0]    write_data,
	dtsm_req_if.sink             request,
	dtsm_res_if.source           result
);

	dtsm_cmd_t    cmd;
	dtsm_status_t status;

	// Controller.
	dtsm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (request.valid),
		.req_ready (request.ready),
		.cmd       (cmd),
		.status    (status)
	);

	// Datapath.
	dtsm_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.write_enable  (write_enable),
		.write_index   (write_index),
		.write_data    (write_data),
		.end_of_buffer (request.end_of_buffer),
		.cmd           (cmd),
		.status        (status),
		.result        (result)
	);

endmodule
